// File: src/bzj_pkg.sv
// Package for the Bezier triangle Jacobian validity unit: sizes, the term
// schedule of the Jacobian coefficients and the divisor table. No dependencies.
`default_nettype none
package bzj_pkg;

  localparam int NPTS      = 10;  // control points of a cubic triangle
  localparam int NCOEF     = 15;  // coefficients of the quartic Jacobian
  localparam int NTERM     = 36;  // cross-product terms over all coefficients
  localparam int PT_WIDTH  = 64;  // x in the low half, y in the high half
  localparam int DIV_STEPS = 11;  // byte digits of the 88-bit dividend

  typedef logic [3:0] pt_idx_t;

  // One cross-product term: lower-degree nodes n1, n2 (0..5) and a flag that
  // closes the current coefficient.
  typedef struct packed {
    logic [2:0] n1;
    logic [2:0] n2;
    logic       last;
  } term_t;

  // Rounded division by den = 2^(shift-1) * (by3 ? 3 : 1).
  typedef struct packed {
    logic [1:0] shift;
    logic       by3;
    logic [3:0] den;
  } div_t;

  // Degree-2 nodes: 0 (2,0), 1 (0,2), 2 (0,0), 3 (1,1), 4 (1,0), 5 (0,1).
  // Terms are listed in coefficient slot order.
  function automatic term_t term_at(logic [5:0] t);
    term_t r;
    r = '0;
    case (t)
      6'd0:  r = '{3'd0, 3'd0, 1'b1};
      6'd1:  r = '{3'd1, 3'd1, 1'b1};
      6'd2:  r = '{3'd2, 3'd2, 1'b1};
      6'd3:  r = '{3'd0, 3'd3, 1'b0};
      6'd4:  r = '{3'd3, 3'd0, 1'b1};
      6'd5:  r = '{3'd0, 3'd1, 1'b0};
      6'd6:  r = '{3'd1, 3'd0, 1'b0};
      6'd7:  r = '{3'd3, 3'd3, 1'b1};
      6'd8:  r = '{3'd1, 3'd3, 1'b0};
      6'd9:  r = '{3'd3, 3'd1, 1'b1};
      6'd10: r = '{3'd1, 3'd5, 1'b0};
      6'd11: r = '{3'd5, 3'd1, 1'b1};
      6'd12: r = '{3'd1, 3'd2, 1'b0};
      6'd13: r = '{3'd2, 3'd1, 1'b0};
      6'd14: r = '{3'd5, 3'd5, 1'b1};
      6'd15: r = '{3'd2, 3'd5, 1'b0};
      6'd16: r = '{3'd5, 3'd2, 1'b1};
      6'd17: r = '{3'd2, 3'd4, 1'b0};
      6'd18: r = '{3'd4, 3'd2, 1'b1};
      6'd19: r = '{3'd0, 3'd2, 1'b0};
      6'd20: r = '{3'd2, 3'd0, 1'b0};
      6'd21: r = '{3'd4, 3'd4, 1'b1};
      6'd22: r = '{3'd0, 3'd4, 1'b0};
      6'd23: r = '{3'd4, 3'd0, 1'b1};
      6'd24: r = '{3'd0, 3'd5, 1'b0};
      6'd25: r = '{3'd5, 3'd0, 1'b0};
      6'd26: r = '{3'd3, 3'd4, 1'b0};
      6'd27: r = '{3'd4, 3'd3, 1'b1};
      6'd28: r = '{3'd1, 3'd4, 1'b0};
      6'd29: r = '{3'd4, 3'd1, 1'b0};
      6'd30: r = '{3'd3, 3'd5, 1'b0};
      6'd31: r = '{3'd5, 3'd3, 1'b1};
      6'd32: r = '{3'd2, 3'd3, 1'b0};
      6'd33: r = '{3'd3, 3'd2, 1'b0};
      6'd34: r = '{3'd4, 3'd5, 1'b0};
      6'd35: r = '{3'd5, 3'd4, 1'b1};
      default: r = '0;
    endcase
    return r;
  endfunction

  // First difference operand: a1 - a0 taken at (i+1,j) and (i,j+1).
  function automatic pt_idx_t node_a0(logic [2:0] n);
    pt_idx_t r;
    case (n)
      3'd0: r = 4'd0;
      3'd1: r = 4'd4;
      3'd2: r = 4'd7;
      3'd3: r = 4'd3;
      3'd4: r = 4'd8;
      3'd5: r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic pt_idx_t node_a1(logic [2:0] n);
    pt_idx_t r;
    case (n)
      3'd0: r = 4'd3;
      3'd1: r = 4'd1;
      3'd2: r = 4'd6;
      3'd3: r = 4'd4;
      3'd4: r = 4'd9;
      3'd5: r = 4'd5;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // Second difference operand: b1 - b0 taken at (i,j) and (i+1,j).
  function automatic pt_idx_t node_b0(logic [2:0] n);
    pt_idx_t r;
    case (n)
      3'd0: r = 4'd0;
      3'd1: r = 4'd4;
      3'd2: r = 4'd7;
      3'd3: r = 4'd3;
      3'd4: r = 4'd8;
      3'd5: r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic pt_idx_t node_b1(logic [2:0] n);
    pt_idx_t r;
    case (n)
      3'd0: r = 4'd8;
      3'd1: r = 4'd5;
      3'd2: r = 4'd2;
      3'd3: r = 4'd9;
      3'd4: r = 4'd7;
      3'd5: r = 4'd6;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // d*d times both trinomial weights; corner nodes weigh 1, the others 2.
  function automatic logic [5:0] term_weight(logic [2:0] n1, logic [2:0] n2);
    logic w1;
    logic w2;
    w1 = (n1 >= 3'd3);
    w2 = (n2 >= 3'd3);
    case ({w1, w2})
      2'b00:   return 6'd9;
      2'b11:   return 6'd36;
      default: return 6'd18;
    endcase
  endfunction

  function automatic div_t div_of(logic [3:0] slot);
    div_t r;
    case (slot)
      4'd0, 4'd1, 4'd2:                     r = '{2'd1, 1'b0, 4'd1};
      4'd4, 4'd7, 4'd10:                    r = '{2'd2, 1'b1, 4'd6};
      4'd12, 4'd13, 4'd14:                  r = '{2'd3, 1'b1, 4'd12};
      default:                              r = '{2'd3, 1'b0, 4'd4};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/bzj_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bzj_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/bezier_tri_jacobian_validity_unit.sv
// Top level of the Bezier triangle Jacobian validity unit.
// Uses bzj_pkg and one bzj_ram for the control points.
//
//  channel  | direction | handshake            | word
//  point    | in        | point_valid/stall    | point_x, point_y, point_slot, point_last
//  coeff    | out       | coeff_valid/stall    | coeff_slot, coeff_value, verdict, result_last
//  cfg      | in        | cfg_valid/cfg_ready  | min_acceptable
//
// A point not marked last is taken whenever the unit is idle. The last point starts
// a run: each of the 36 terms takes reads through the single read port of the point
// memory, two passes through the shared multiplier, a weight multiply and an
// accumulate; then each coefficient takes a setup step, 11 byte steps of divide by
// three on the six slots whose divisor holds a factor of three, and an output step.
// point_stall stays high for the whole run; a stalled output word holds the run at
// its next coefficient. Synchronous reset, no clearing pass.
`default_nettype none
module bezier_tri_jacobian_validity_unit
  import bzj_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  output logic               point_stall,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic [3:0]         point_slot,
  input  logic               point_last,
  output logic               coeff_valid,
  input  logic               coeff_stall,
  output logic [3:0]         coeff_slot,
  output logic signed [63:0] coeff_value,
  output logic [1:0]         verdict,
  output logic               result_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [63:0] min_acceptable
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_WGT  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_PREP = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]         state;
  logic signed [63:0] min_reg;
  logic [2:0]         rc;
  logic [5:0]         ti;
  logic [3:0]         cs;
  logic [3:0]         dc;
  logic [2:0]         below;

  logic signed [31:0] px, py;
  logic signed [32:0] ax, ay, bx, by;
  logic signed [65:0] m1, m2;
  logic signed [72:0] wt;
  logic signed [79:0] acc;
  logic               neg;
  logic [87:0]        dv;
  logic [1:0]         rem;

  term_t              term;
  div_t               dsel;
  pt_idx_t            raddr;
  logic [63:0]        rdata;
  logic signed [31:0] rd_x, rd_y;
  logic               accept, we;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [66:0] cross_p;
  logic signed [6:0]  wsg;

  logic [79:0]        mag;
  logic [81:0]        numer;
  logic [81:0]        shifted;
  logic [9:0]         cur;
  logic [20:0]        qprod;
  logic [7:0]         qd;
  logic [9:0]         rback;
  logic [9:0]         rnext;
  logic               big;
  logic [63:0]        qlow;
  logic signed [63:0] value_c;
  logic               out_free;
  logic [1:0]         verdict_c;

  assign term        = term_at(ti);
  assign dsel        = div_of(cs);
  assign point_stall = (state != S_IDLE);
  assign accept      = point_valid && !point_stall;
  assign we          = accept && (point_slot < 4'(NPTS));
  assign cfg_ready   = 1'b1;

  always_comb begin
    case (rc)
      3'd0:    raddr = node_a0(term.n1);
      3'd1:    raddr = node_a1(term.n1);
      3'd2:    raddr = node_b0(term.n2);
      default: raddr = node_b1(term.n2);
    endcase
  end

  bzj_ram #(
    .WIDTH(PT_WIDTH),
    .DEPTH(NPTS)
  ) u_points (
    .clk  (clk),
    .we   (we),
    .waddr(point_slot),
    .wdata({point_y, point_x}),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_x = rdata[31:0];
  assign rd_y = rdata[63:32];

  // one multiplier serves both cross-product halves
  assign mul_a   = (state == S_MUL1) ? ax : ay;
  assign mul_b   = (state == S_MUL1) ? by : bx;
  assign mul_p   = mul_a * mul_b;
  assign cross_p = {m1[65], m1} - {m2[65], m2};
  assign wsg     = {1'b0, term_weight(term.n1, term.n2)};

  // round half away from zero: floor((2|s| + den) / (2 den))
  assign mag     = acc[79] ? (80'd0 - acc) : acc;
  assign numer   = {1'b0, mag, 1'b0} + {78'd0, dsel.den};
  assign shifted = numer >> dsel.shift;

  // divide by three a byte at a time, reciprocal 683/2048
  assign cur   = {rem, dv[87:80]};
  assign qprod = {11'd0, cur} * 21'd683;
  assign qd    = qprod[18:11];
  assign rback = {2'b00, qd} + {1'b0, qd, 1'b0};
  assign rnext = cur - rback;

  assign big  = |dv[87:63];
  assign qlow = {1'b0, dv[62:0]};
  always_comb begin
    if (neg) begin
      value_c = big ? 64'sh8000_0000_0000_0000 : -$signed(qlow);
    end else begin
      value_c = big ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(qlow);
    end
  end

  assign out_free = !coeff_valid || !coeff_stall;

  always_comb begin
    if (below[0]) begin
      verdict_c = 2'd1;
    end else if (below[1]) begin
      verdict_c = 2'd2;
    end else if (below[2]) begin
      verdict_c = 2'd3;
    end else begin
      verdict_c = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      min_reg <= min_acceptable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rc          <= '0;
      ti          <= '0;
      cs          <= '0;
      dc          <= '0;
      below       <= '0;
      coeff_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        coeff_valid <= 1'b1;
      end else if (!coeff_stall) begin
        coeff_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && point_last) begin
            state <= S_READ;
            rc    <= '0;
            ti    <= '0;
            cs    <= '0;
            below <= '0;
          end
        end
        S_READ: begin
          if (rc == 3'd4) begin
            state <= S_MUL1;
            rc    <= '0;
          end else begin
            rc <= rc + 3'd1;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_WGT;
        S_WGT:  state <= S_ACC;
        S_ACC: begin
          if (term.last) begin
            state <= S_PREP;
          end else begin
            ti    <= ti + 6'd1;
            state <= S_READ;
          end
        end
        S_PREP: begin
          dc    <= '0;
          state <= dsel.by3 ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (dc == 4'(DIV_STEPS - 1)) begin
            state <= S_OUT;
          end else begin
            dc <= dc + 4'd1;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            if (cs < 4'd3) begin
              below[cs[1:0]] <= (value_c < min_reg);
            end
            if (cs == 4'(NCOEF - 1)) begin
              state <= S_IDLE;
            end else begin
              cs    <= cs + 4'd1;
              ti    <= ti + 6'd1;
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath words, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: acc <= '0;
      S_READ: begin
        case (rc)
          3'd1, 3'd3: begin
            px <= rd_x;
            py <= rd_y;
          end
          3'd2: begin
            ax <= {rd_x[31], rd_x} - {px[31], px};
            ay <= {rd_y[31], rd_y} - {py[31], py};
          end
          3'd4: begin
            bx <= {rd_x[31], rd_x} - {px[31], px};
            by <= {rd_y[31], rd_y} - {py[31], py};
          end
          default: ;
        endcase
      end
      S_MUL1: m1 <= mul_p;
      S_MUL2: m2 <= mul_p;
      S_WGT:  wt <= cross_p * wsg;
      S_ACC:  acc <= acc + {{7{wt[72]}}, wt};
      S_PREP: begin
        neg <= acc[79];
        dv  <= {6'd0, shifted};
        rem <= '0;
        acc <= '0;
      end
      S_DIV: begin
        dv  <= {dv[79:0], qd};
        rem <= rnext[1:0];
      end
      S_OUT: begin
        if (out_free) begin
          coeff_slot  <= cs;
          coeff_value <= value_c;
          result_last <= (cs == 4'(NCOEF - 1));
          verdict     <= (cs == 4'(NCOEF - 1)) ? verdict_c : 2'd0;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: src/bzj_check.sv
// Port-level checker for the Jacobian validity unit, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module bzj_check (
  input logic        clk,
  input logic        rst,
  input logic        point_valid,
  input logic        point_stall,
  input logic        point_last,
  input logic        coeff_valid,
  input logic        coeff_stall,
  input logic [3:0]  coeff_slot,
  input logic [63:0] coeff_value,
  input logic [1:0]  verdict,
  input logic        result_last
);

  // a run starts only on an accepted last point
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    $rose(point_stall) |-> $past(point_valid && point_last))
    else $error("input closed without a last point");

  // a new word is produced only during a run
  a_out_in_run: assert property (@(posedge clk) disable iff (rst)
    $rose(coeff_valid) |-> $past(point_stall))
    else $error("output word appeared outside a run");

  // verdict is zero except on the closing word
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    coeff_valid && !result_last |-> verdict == 2'd0)
    else $error("verdict set before the last word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    coeff_valid && coeff_stall |=>
      coeff_valid && $stable(coeff_value) && $stable(coeff_slot))
    else $error("stalled output word changed");

endmodule

bind bezier_tri_jacobian_validity_unit bzj_check u_check (
  .clk        (clk),
  .rst        (rst),
  .point_valid(point_valid),
  .point_stall(point_stall),
  .point_last (point_last),
  .coeff_valid(coeff_valid),
  .coeff_stall(coeff_stall),
  .coeff_slot (coeff_slot),
  .coeff_value(coeff_value),
  .verdict    (verdict),
  .result_last(result_last)
);
`default_nettype wire

// File: tb/bezier_tri_jacobian_validity_unit_tb.sv
// Testbench for bezier_tri_jacobian_validity_unit: loads cubic triangles and checks
// the 15 Jacobian coefficients and the corner verdict against a local predictor.
// Depends on bzj_pkg and the unit under test.
`timescale 1ns / 1ps
module bezier_tri_jacobian_validity_unit_tb;
  import bzj_pkg::*;

  localparam logic [1:0] VERDICT_VALID   = 2'd0;
  localparam logic [1:0] VERDICT_CORNER0 = 2'd1;
  localparam int         CFG_INDEX       = 0;
  localparam int         IDLE_LIMIT      = 20000;
  localparam int         LONG_HOLD       = 400;

  typedef struct {
    logic [3:0]         slot;
    logic signed [63:0] value;
    logic [1:0]         verdict;
    logic               last;
  } coeff_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               point_valid = 1'b0;
  logic               point_stall;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic [3:0]         point_slot = '0;
  logic               point_last = 1'b0;
  logic               coeff_valid;
  logic               coeff_stall = 1'b0;
  logic [3:0]         coeff_slot;
  logic signed [63:0] coeff_value;
  logic [1:0]         verdict;
  logic               result_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic signed [63:0] min_acceptable = '0;

  coeff_word_t        coeff_expected[$];
  longint             pred_x[NPTS];
  longint             pred_y[NPTS];
  longint             pred_threshold;
  int                 errors = 0;
  bit                 quiet = 1'b0;
  int                 hold_token = 0;

  bezier_tri_jacobian_validity_unit u_top (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall),
    .point_x(point_x), .point_y(point_y), .point_slot(point_slot),
    .point_last(point_last),
    .coeff_valid(coeff_valid), .coeff_stall(coeff_stall),
    .coeff_slot(coeff_slot), .coeff_value(coeff_value), .verdict(verdict),
    .result_last(result_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .min_acceptable(min_acceptable)
  );

  always #2 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic int node_idx(int p, int i, int j);
    int k;
    k = p - i - j;
    if (i == p) return 0;
    if (j == p) return 1;
    if (k == p) return 2;
    if (k == 0) return 2 + j;
    if (i == 0) return 1 + p + k;
    if (j == 0) return 2 * p + i;
    return k * (p - 1) - k * (k - 1) / 2 + j + 2 * p;
  endfunction

  function automatic longint fact(int n);
    longint f;
    f = 1;
    for (int m = 2; m <= n; m++) f = f * m;
    return f;
  endfunction

  function automatic longint trinom(int n, int i, int j);
    if (i < 0 || j < 0 || n - i - j < 0) return 0;
    return fact(n) / (fact(i) * fact(j) * fact(n - i - j));
  endfunction

  function automatic logic signed [63:0] jac_coeff(int ci, int cj);
    logic signed [127:0] sum, ta, tb;
    logic [127:0] mag, q, r;
    longint ax, ay, bx, by, w, den;
    int lo, hi, i2, j2, a0, a1, b0, b1;
    bit neg;
    sum = '0;
    for (int j1 = 0; j1 <= cj; j1++) begin
      lo = ci + cj - j1 - 2;
      hi = 2 - j1;
      if (lo < 0) lo = 0;
      if (hi > ci) hi = ci;
      for (int i1 = lo; i1 <= hi; i1++) begin
        i2 = ci - i1;
        j2 = cj - j1;
        a0 = node_idx(3, i1 + 1, j1);
        a1 = node_idx(3, i1, j1 + 1);
        b0 = node_idx(3, i2 + 1, j2);
        b1 = node_idx(3, i2, j2);
        ax = pred_x[a1] - pred_x[a0];
        ay = pred_y[a1] - pred_y[a0];
        bx = pred_x[b1] - pred_x[b0];
        by = pred_y[b1] - pred_y[b0];
        ta = ax;
        ta = ta * by;
        tb = ay;
        tb = tb * bx;
        w = trinom(2, i1, j1) * trinom(2, i2, j2);
        sum = sum + (ta - tb) * w;
      end
    end
    sum = sum * 9;
    den = trinom(4, ci, cj);
    neg = sum[127];
    mag = neg ? -sum : sum;
    q = mag / den;
    r = mag % den;
    if (2 * r >= den) q = q + 1;
    if (!neg) return (q > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF : q[63:0];
    if (q >= 128'h8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return -q[63:0];
  endfunction

  task automatic predict_point(logic [31:0] x, logic [31:0] y, logic [3:0] slot, logic last);
    longint coeffs[NCOEF];
    coeff_word_t wd;
    logic [1:0] vd;
    if (slot < NPTS) begin
      pred_x[slot] = longint'(signed'(x));
      pred_y[slot] = longint'(signed'(y));
    end
    if (last) begin
      for (int ci = 0; ci <= 4; ci++)
        for (int cj = 0; cj <= 4 - ci; cj++)
          coeffs[node_idx(4, ci, cj)] = jac_coeff(ci, cj);
      vd = VERDICT_VALID;
      for (int n = 2; n >= 0; n--)
        if (coeffs[n] < pred_threshold) vd = 2'(VERDICT_CORNER0 + n);
      for (int n = 0; n < NCOEF; n++) begin
        wd.slot = 4'(n);
        wd.value = coeffs[n];
        wd.verdict = (n == NCOEF - 1) ? vd : VERDICT_VALID;
        wd.last = (n == NCOEF - 1);
        coeff_expected.push_back(wd);
      end
    end
  endtask

  // ---------------- checker ----------------
  always @(posedge clk) begin
    coeff_word_t wd;
    if (!rst && coeff_valid && !coeff_stall) begin
      if (coeff_expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected coeff word slot %0d value %0d", coeff_slot,
                                   coeff_value);
      end else begin
        wd = coeff_expected.pop_front();
        if (coeff_slot !== wd.slot || coeff_value !== wd.value ||
            verdict !== wd.verdict || result_last !== wd.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp slot %0d value %0d verdict %0d last %0d, got %0d %0d %0d %0d",
                     wd.slot, wd.value, wd.verdict, wd.last,
                     coeff_slot, coeff_value, verdict, result_last);
        end
      end
    end
  end

  // ---------------- output stall ----------------
  always @(posedge clk) begin
    static int burst = 0;
    static int hold = 0;
    static int seen = 0;
    static int calm = 0;
    if (rst) begin
      coeff_stall <= 1'b0;
    end else if (hold_token != seen) begin
      seen = hold_token;
      hold = LONG_HOLD;
      coeff_stall <= 1'b1;
    end else if (hold > 0) begin
      hold--;
      coeff_stall <= 1'b1;
    end else if (burst > 0) begin
      burst--;
      coeff_stall <= 1'b1;
    end else begin
      if (calm > 0) calm--;
      else if ($urandom_range(0, 150) == 0) calm = $urandom_range(50, 200);
      if (!quiet && calm == 0 && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 3);
        coeff_stall <= 1'b1;
      end else begin
        coeff_stall <= 1'b0;
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    static int idle = 0;
    if (rst || (point_valid && !point_stall) || (coeff_valid && !coeff_stall) ||
        (cfg_valid && cfg_ready))
      idle = 0;
    else if (++idle >= IDLE_LIMIT) begin
      $display("bezier_tri_jacobian_validity_unit_tb failed");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return 32'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [3:0] slot, logic last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      point_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    point_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_slot <= slot;
    point_last <= last;
    do @(posedge clk); while (point_stall);
    predict_point(x, y, slot, last);
  endtask

  task automatic wait_drain();
    point_valid <= 1'b0;
    while (coeff_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_threshold(logic signed [63:0] thr);
    wait_drain();
    cfg_valid <= 1'b1;
    min_acceptable <= thr;
    do @(posedge clk); while (!cfg_ready);
    pred_threshold = thr;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_triangle();
    int order[NPTS];
    int k, t;
    for (int n = 0; n < NPTS; n++) order[n] = n;
    for (int n = NPTS - 1; n > 0; n--) begin
      k = $urandom_range(0, n);
      t = order[n]; order[n] = order[k]; order[k] = t;
    end
    for (int n = 0; n < NPTS; n++)
      send_point(rand_coord(), rand_coord(), 4'(order[n]), n == NPTS - 1);
  endtask

  task automatic test_directed();
    // identity-like triangle, all slots written by the first last word, then extreme points
    for (int n = 0; n < NPTS; n++)
      send_point(32'(n) << 16, 32'(n * n) << 16, 4'(n), n == NPTS - 1);
    for (int n = 0; n < NPTS; n++)
      send_point((n % 2) ? 32'h7FFF_FFFF : 32'h8000_0000,
                 (n % 3) ? 32'h8000_0000 : 32'h7FFF_FFFF, 4'(n), n == NPTS - 1);
    send_point(32'h0, 32'h0, 4'd0, 1'b0);
    send_point(32'h0001_0000, 32'hFFFF_0000, 4'd0, 1'b0); // overwrite same slot
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1); // stores nothing, runs
    send_point(32'h1234_5678, 32'h8765_4321, 4'd10, 1'b0);
    send_point(32'h0, 32'h7FFF_FFFF, 4'd9, 1'b1);
  endtask

  task automatic test_thresholds();
    write_threshold(64'sh8000_0000_0000_0000);
    send_triangle();
    write_threshold(64'sh7FFF_FFFF_FFFF_FFFF);
    send_triangle();
    write_threshold(64'sh0000_0001_0000_0000);
    send_triangle();
  endtask

  task automatic test_backpressure();
    wait_drain();
    hold_token++;
    send_triangle();
    send_triangle();
    wait_drain();
  endtask

  task automatic test_random(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) == 0) begin
        write_threshold($urandom_range(0, 1) ? {$urandom(), $urandom()}
                                             : 64'($signed($urandom_range(0, 2000)) - 1000) << 32);
      end
      if ($urandom_range(0, 4) == 0) begin
        send_point(rand_coord(), rand_coord(), 4'($urandom_range(0, 15)),
                   $urandom_range(0, 5) == 0);
        sent++;
      end else begin
        send_triangle();
        sent += NPTS;
      end
    end
  endtask

  initial begin
    pred_threshold = 0;
    for (int n = 0; n < NPTS; n++) begin
      pred_x[n] = 0;
      pred_y[n] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_thresholds();
    test_backpressure();
    test_random(300);
    quiet = 1'b1;
    test_random(60);
    wait_drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("bezier_tri_jacobian_validity_unit_tb passed");
    else $display("bezier_tri_jacobian_validity_unit_tb failed");
    $finish;
  end

endmodule
